// File: hdl/sspb_pkg.sv
// ----------------------------------------------------------------------------
// sspb_pkg: shared types, constants and microcode for the speed slew planner
// fixed-point formats, register indexes, control word and its program
// ----------------------------------------------------------------------------
package sspb_pkg;

	// fraction bits of the q formats
	localparam int Q_FRAC_BITS = 15;

	// fixed field widths
	localparam int SPEED_W = 16;
	localparam int PCT_W = 7;
	localparam int OBST_W = 14;
	localparam int PITCH_W = 12;
	localparam int LIMIT_W = 11;
	localparam int STEP_W = 15;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam int IN_DATA_W = 96;
	localparam int IN_USER_W = 4;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam int PRESSURE_CAP = 90;
	localparam int FULL_TURN_TENTHS = 3600;

	// register reset values
	localparam logic [15:0] MIN_RATIO_RST = 16'd29491;
	localparam logic [14:0] ACCEL_RST = 15'd400;
	localparam logic [14:0] DECEL_RST = 15'd400;
	localparam logic [6:0] BASE_PRESS_RST = 7'd0;
	localparam logic [6:0] BOOST_RST = 7'd15;
	localparam logic [13:0] NEAR_RST = 14'd200;
	localparam logic [10:0] PITCH_LIM_RST = 11'd300;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RATIO = 3'd0,
		REG_ACCEL_STEP = 3'd1,
		REG_DECEL_STEP = 3'd2,
		REG_BASE_PRESSURE = 3'd3,
		REG_BOOST_PCT = 3'd4,
		REG_NEAR_DISTANCE = 3'd5,
		REG_PITCH_LIMIT = 3'd6
	} reg_idx_t;

	// datapath operations, one per control word
	typedef enum logic [2:0] {
		OP_BRAKE,
		OP_MUL_BRAKE,
		OP_FACTOR,
		OP_MUL_SPEED,
		OP_FINISH
	} op_t;

	localparam int UC_ADDR_W = 3;
	localparam int UC_DEPTH = 1 << UC_ADDR_W;

	typedef logic [UC_ADDR_W-1:0] ustep_t;

	localparam ustep_t STEP_FINISH = 3'd4;

	typedef struct packed {
		op_t op;
		logic jmp_ovr;   // jump when the override flag is set
		ustep_t jmp_step;
	} ctrl_t;

	// brake, scale, factor, scale speed, finish; override skips the scaling
	localparam ctrl_t UCODE [UC_DEPTH] = '{
		'{op: OP_BRAKE, jmp_ovr: 1'b1, jmp_step: STEP_FINISH},
		'{op: OP_MUL_BRAKE, jmp_ovr: 1'b0, jmp_step: STEP_FINISH},
		'{op: OP_FACTOR, jmp_ovr: 1'b0, jmp_step: STEP_FINISH},
		'{op: OP_MUL_SPEED, jmp_ovr: 1'b0, jmp_step: STEP_FINISH},
		'{op: OP_FINISH, jmp_ovr: 1'b0, jmp_step: STEP_FINISH},
		'{op: OP_FINISH, jmp_ovr: 1'b0, jmp_step: STEP_FINISH},
		'{op: OP_FINISH, jmp_ovr: 1'b0, jmp_step: STEP_FINISH},
		'{op: OP_FINISH, jmp_ovr: 1'b0, jmp_step: STEP_FINISH}
	};

endpackage

// File: hdl/speed_slew_planner_with_boost.sv
// ----------------------------------------------------------------------------
// speed_slew_planner_with_boost: per-tick speed ramp and suction boost
// brake-scaled target speed, slew-limited held speed, boost flag and percent
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ---------------------------------
//  s_axis    in   s_axis_tvalid/tready      tick inputs (tdata, tuser)
//  m_axis    out  m_axis_tvalid/tready      planned speed and pressure command
//  cfg       in   cfg_wr_en                 cfg_index, cfg_data, no read-back
//
//  a transaction steps through the microcode: brake, scale, factor, scale speed,
//  finish (override jumps from brake to finish), on one shared 18x18 multiplier
//  s_axis_tready is high whenever the sequencer is idle
//  the finish step waits while the output register holds an untaken result
//  arst_n clears config to defaults, held speed and boost flag to zero
//
module speed_slew_planner_with_boost (
	input logic clk,
	input logic arst_n,
	// base_speed[15:0], lat_error[31:16], curvature[47:32],
	// override_speed[63:48], obstacle_mm[77:64], pitch_angle[89:78], zero[95:90]
	input logic [sspb_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// override_active[0], safety_inhibit[1], drive_enabled[2], pitch_valid[3]
	input logic [sspb_pkg::IN_USER_W-1:0] s_axis_tuser,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// planned_speed[15:0], pressure_percent[22:16], zero[23]
	output logic [sspb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// pressure_write[0], boost_active[1]
	output logic [sspb_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic cfg_wr_en,
	input logic [sspb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sspb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sspb_pkg::*;

	// width that holds one (2^q) and the magnitude of a 16 bit value
	localparam int AW = (Q_FRAC_BITS + 2 > 17) ? Q_FRAC_BITS + 2 : 17;
	localparam int MUL_W = AW + 1;
	localparam int PW = 2 * MUL_W;
	localparam int TGT_W = SPEED_W + 2;
	localparam logic [AW-1:0] ONE = AW'(1) << Q_FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (Q_FRAC_BITS - 1);
	localparam logic [PITCH_W-1:0] FULL_TURN = PITCH_W'(FULL_TURN_TENTHS);
	localparam logic [PCT_W:0] CAP = (PCT_W + 1)'(PRESSURE_CAP);

	// configuration registers
	logic [15:0] min_ratio_q;
	logic [14:0] accel_step_q;
	logic [14:0] decel_step_q;
	logic [PCT_W-1:0] base_pressure_q;
	logic [PCT_W-1:0] boost_pct_q;
	logic [OBST_W-1:0] near_distance_q;
	logic [LIMIT_W-1:0] pitch_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ratio_q <= MIN_RATIO_RST;
			accel_step_q <= ACCEL_RST;
			decel_step_q <= DECEL_RST;
			base_pressure_q <= BASE_PRESS_RST;
			boost_pct_q <= BOOST_RST;
			near_distance_q <= NEAR_RST;
			pitch_limit_q <= PITCH_LIM_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_RATIO: min_ratio_q <= cfg_data;
				REG_ACCEL_STEP: accel_step_q <= cfg_data[STEP_W-1:0];
				REG_DECEL_STEP: decel_step_q <= cfg_data[STEP_W-1:0];
				REG_BASE_PRESSURE: base_pressure_q <= cfg_data[PCT_W-1:0];
				REG_BOOST_PCT: boost_pct_q <= cfg_data[PCT_W-1:0];
				REG_NEAR_DISTANCE: near_distance_q <= cfg_data[OBST_W-1:0];
				REG_PITCH_LIMIT: pitch_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ; // indexes beyond the list are ignored
			endcase
		end
	end

	// captured transaction fields (payload, no reset)
	logic signed [SPEED_W-1:0] base_q, err_q, curv_q, ovr_speed_q;
	logic [OBST_W-1:0] obst_q;
	logic [PITCH_W-1:0] pitch_q;
	logic ovr_q, inhibit_q, enabled_q, pvalid_q;

	// sequencer control
	logic busy_q;
	ustep_t step_q;
	ustep_t step_nxt;
	ctrl_t cw;
	logic in_fire;
	logic out_free;
	logic finish;

	assign cw = UCODE[step_q];
	assign s_axis_tready = !busy_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	// the last step retires only into a free output slot
	assign finish = busy_q && (cw.op == OP_FINISH) && out_free;

	always_comb begin
		step_nxt = step_q;
		if (in_fire) begin
			step_nxt = '0;
		end else if (busy_q && cw.op != OP_FINISH) begin
			if (cw.jmp_ovr && ovr_q) begin
				step_nxt = cw.jmp_step;
			end else begin
				step_nxt = step_q + ustep_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			step_q <= step_nxt;
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q <= s_axis_tdata[15:0];
			err_q <= s_axis_tdata[31:16];
			curv_q <= s_axis_tdata[47:32];
			ovr_speed_q <= s_axis_tdata[63:48];
			obst_q <= s_axis_tdata[77:64];
			pitch_q <= s_axis_tdata[89:78];
			ovr_q <= s_axis_tuser[0];
			inhibit_q <= s_axis_tuser[1];
			enabled_q <= s_axis_tuser[2];
			pvalid_q <= s_axis_tuser[3];
		end
	end

	// brake: larger of the clamped magnitudes of error and curvature
	logic signed [AW-1:0] err_ext, curv_ext;
	logic [AW-1:0] err_abs, curv_abs, err_mag, curv_mag, ratio;
	logic [AW-1:0] brake_q, omr_q, factor_q;

	always_comb begin
		err_ext = AW'(err_q);
		curv_ext = AW'(curv_q);
		err_abs = err_ext[AW-1] ? AW'(-err_ext) : AW'(err_ext);
		curv_abs = curv_ext[AW-1] ? AW'(-curv_ext) : AW'(curv_ext);
		err_mag = (err_abs > ONE) ? ONE : err_abs;
		curv_mag = (curv_abs > ONE) ? ONE : curv_abs;
		// a ratio above one behaves as one
		ratio = (AW'(min_ratio_q) > ONE) ? ONE : AW'(min_ratio_q);
	end

	// shared multiplier, operands picked by the control word
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] rnd;

	always_comb begin
		if (cw.op == OP_MUL_SPEED) begin
			mul_a = MUL_W'(base_q);
			mul_b = $signed({1'b0, factor_q});
		end else begin
			mul_a = $signed({1'b0, omr_q});
			mul_b = $signed({1'b0, brake_q});
		end
		// round to nearest, ties toward plus infinity
		rnd = (prod_q + $signed(HALF)) >>> Q_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			case (cw.op)
				OP_BRAKE: begin
					brake_q <= (err_mag > curv_mag) ? err_mag : curv_mag;
					omr_q <= ONE - ratio;
				end
				OP_MUL_BRAKE, OP_MUL_SPEED: prod_q <= mul_a * mul_b;
				OP_FACTOR: factor_q <= ONE - rnd[AW-1:0];
				default: ;
			endcase
		end
	end

	// ramp of the held speed toward the target
	logic signed [SPEED_W-1:0] held_q;
	logic signed [TGT_W-1:0] target, held_ext, delta, lim, step_d, sum;
	logic signed [SPEED_W-1:0] held_nxt;

	always_comb begin
		target = rnd[TGT_W-1:0];
		held_ext = TGT_W'(held_q);
		delta = target - held_ext;
		lim = (delta > 0) ? $signed(TGT_W'(accel_step_q)) : $signed(TGT_W'(decel_step_q));
		if (delta > lim) begin
			step_d = lim;
		end else if (delta < -lim) begin
			step_d = -lim;
		end else begin
			step_d = delta;
		end
		sum = held_ext + step_d;
		if (ovr_q) begin
			held_nxt = ovr_speed_q;
		end else if (sum > $signed(TGT_W'(32767))) begin
			held_nxt = 16'sh7fff;
		end else if (sum < -$signed(TGT_W'(32768))) begin
			held_nxt = 16'sh8000;
		end else begin
			held_nxt = sum[SPEED_W-1:0];
		end
	end

	// boost condition and suction command
	logic boost_q;
	logic near, pitch_hit, act, boost_nxt, wr_nxt;
	logic [PCT_W:0] eff;
	logic [PCT_W-1:0] pct_nxt;

	always_comb begin
		near = obst_q < near_distance_q;
		pitch_hit = pvalid_q && (pitch_q > PITCH_W'(pitch_limit_q))
			&& (pitch_q < FULL_TURN - PITCH_W'(pitch_limit_q));
		act = near || pitch_hit;
		eff = (PCT_W + 1)'(base_pressure_q) + (PCT_W + 1)'(boost_pct_q);
		if (eff > CAP) begin
			eff = CAP;
		end
		boost_nxt = 1'b0;
		wr_nxt = 1'b0;
		pct_nxt = '0;
		if (!inhibit_q && enabled_q) begin
			boost_nxt = act;
			if (act) begin
				wr_nxt = 1'b1;
				pct_nxt = eff[PCT_W-1:0];
			end else if (boost_q) begin
				// boost just ended: restore the base level
				wr_nxt = 1'b1;
				pct_nxt = base_pressure_q;
			end
		end
	end

	// state and output register
	logic out_valid_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic [PCT_W-1:0] out_pct_q;
	logic out_wr_q, out_boost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			boost_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				held_q <= held_nxt;
				boost_q <= boost_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_speed_q <= held_nxt;
			out_pct_q <= pct_nxt;
			out_wr_q <= wr_nxt;
			out_boost_q <= boost_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_pct_q, out_speed_q};
	assign m_axis_tuser = {out_boost_q, out_wr_q};

endmodule

// File: hdl/sspb_checker.sv
// ----------------------------------------------------------------------------
// sspb_checker: port-level checks for the speed slew planner
// output hold under stall, command consistency and input spacing
// ----------------------------------------------------------------------------
module sspb_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [sspb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [sspb_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import sspb_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed under stall");

	// an active boost always issues a percent, capped
	a_boost_writes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]
			&& (m_axis_tdata[22:16] <= PCT_W'(PRESSURE_CAP)))
		else $error("boost without capped write");

	// no write means a zero percent
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[22:16] == '0)
		else $error("percent set without write");

	// the sequencer is still busy in the cycle after it takes a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted back to back");

endmodule

bind speed_slew_planner_with_boost sspb_checker u_sspb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for speed_slew_planner_with_boost
// drives control ticks over the input stream and configuration writes between
// phases, keeps its own copy of the speed ramp and boost state, and checks
// every planned speed and pressure command against it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	import sspb_pkg::*;

	localparam longint Q_ONE = longint'(1) << Q_FRAC_BITS;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;   // no register here
	localparam int USER_WRITE_BIT = 0;
	localparam int USER_BOOST_BIT = 1;
	localparam int MAX_REPORTED = 10;

	// one control tick as the sender sees it
	typedef struct {
		logic signed [SPEED_W-1:0] base_speed;
		logic signed [15:0] lat_error;
		logic signed [15:0] curvature;
		logic override_active;
		logic signed [SPEED_W-1:0] override_speed;
		logic safety_inhibit;
		logic drive_enabled;
		logic [OBST_W-1:0] obstacle_mm;
		logic pitch_valid;
		logic [PITCH_W-1:0] pitch_angle;
	} tick_t;

	// planned speed and pressure command for one tick
	typedef struct {
		logic signed [SPEED_W-1:0] planned_speed;
		logic pressure_write;
		logic [PCT_W-1:0] pressure_percent;
		logic boost_active;
	} plan_t;

	// raw register values as written, masking happens in the block
	typedef struct packed {
		logic [15:0] min_ratio;
		logic [15:0] accel_step;
		logic [15:0] decel_step;
		logic [15:0] base_pressure;
		logic [15:0] boost_pct;
		logic [15:0] near_distance;
		logic [15:0] pitch_limit;
	} cfg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// mirror of the block's registers and state
	int cfg_min_ratio = int'(MIN_RATIO_RST);
	int cfg_accel = int'(ACCEL_RST);
	int cfg_decel = int'(DECEL_RST);
	int cfg_base_pressure = int'(BASE_PRESS_RST);
	int cfg_boost = int'(BOOST_RST);
	int cfg_near = int'(NEAR_RST);
	int cfg_pitch_limit = int'(PITCH_LIM_RST);
	int model_held = 0;
	bit model_boost = 1'b0;

	plan_t expected_plans[$];
	int mismatch_count = 0;

	// idle rates in percent, and the long receiver stall request
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;

	// keeps the obstacle near for a run of ticks so boost spans several ticks
	bit scene_near = 1'b0;

	always #5 clk = ~clk;

	speed_slew_planner_with_boost u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// round to nearest, ties toward plus infinity, drop the q fraction
	function automatic longint q_round(input longint p);
		return (p + (longint'(1) << (Q_FRAC_BITS - 1))) >>> Q_FRAC_BITS;
	endfunction

	// magnitude limited to 1.0, full-scale negative is exactly 1.0
	function automatic longint q_unit_mag(input logic signed [15:0] v);
		longint a;
		a = (v < 0) ? -longint'(v) : longint'(v);
		return (a > Q_ONE) ? Q_ONE : a;
	endfunction

	// advances the mirrored state by one tick and returns the command it gives
	function automatic plan_t plan_tick(input tick_t t);
		plan_t r;
		longint brake, ratio, factor, target, delta, lim, nxt;
		int eff;
		bit hit;
		brake = q_unit_mag(t.lat_error);
		if (q_unit_mag(t.curvature) > brake)
			brake = q_unit_mag(t.curvature);
		ratio = (longint'(cfg_min_ratio) > Q_ONE) ? Q_ONE : longint'(cfg_min_ratio);
		factor = Q_ONE - q_round((Q_ONE - ratio) * brake);
		target = q_round(longint'(t.base_speed) * factor);

		if (t.override_active) begin
			model_held = int'(t.override_speed);
		end else begin
			// a zero distance counts as a fall and uses the decel step
			delta = target - longint'(model_held);
			lim = (delta > 0) ? longint'(cfg_accel) : longint'(cfg_decel);
			if (delta > lim)
				delta = lim;
			else if (delta < -lim)
				delta = -lim;
			nxt = longint'(model_held) + delta;
			if (nxt > 32767)
				nxt = 32767;
			else if (nxt < -32768)
				nxt = -32768;
			model_held = int'(nxt);
		end

		r.pressure_write = 1'b0;
		r.pressure_percent = '0;
		if (t.safety_inhibit || !t.drive_enabled) begin
			model_boost = 1'b0;
		end else begin
			hit = int'(t.obstacle_mm) < cfg_near;
			if (t.pitch_valid && int'(t.pitch_angle) > cfg_pitch_limit &&
					int'(t.pitch_angle) < FULL_TURN_TENTHS - cfg_pitch_limit)
				hit = 1'b1;
			if (hit) begin
				eff = cfg_base_pressure + cfg_boost;
				if (eff > PRESSURE_CAP)
					eff = PRESSURE_CAP;
				r.pressure_write = 1'b1;
				r.pressure_percent = PCT_W'(eff);
			end else if (model_boost) begin
				// boost just ended, base level goes out unclamped
				r.pressure_write = 1'b1;
				r.pressure_percent = PCT_W'(cfg_base_pressure);
			end
			model_boost = hit;
		end
		r.planned_speed = SPEED_W'(model_held);
		r.boost_active = model_boost;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic tick_t mk_tick(input logic signed [15:0] base, input logic signed [15:0] err,
			input logic signed [15:0] curv, input logic ovr, input logic signed [15:0] ovr_speed,
			input logic inhibit, input logic enabled, input logic [OBST_W-1:0] obst,
			input logic pvalid, input logic [PITCH_W-1:0] pitch);
		tick_t t;
		t.base_speed = base;
		t.lat_error = err;
		t.curvature = curv;
		t.override_active = ovr;
		t.override_speed = ovr_speed;
		t.safety_inhibit = inhibit;
		t.drive_enabled = enabled;
		t.obstacle_mm = obst;
		t.pitch_valid = pvalid;
		t.pitch_angle = pitch;
		return t;
	endfunction

	// random tick, biased toward small errors, the near threshold and the pitch window edges
	function automatic tick_t rand_tick();
		tick_t t;
		int v;
		int centre;
		t.base_speed = 16'($urandom);
		if ($urandom_range(3) == 0)
			t.base_speed = t.base_speed >>> $urandom_range(12);
		t.lat_error = 16'($urandom);
		if ($urandom_range(2) != 0)
			t.lat_error = t.lat_error >>> $urandom_range(14, 1);
		t.curvature = 16'($urandom);
		if ($urandom_range(2) != 0)
			t.curvature = t.curvature >>> $urandom_range(14, 1);
		t.override_active = ($urandom_range(9) == 0);
		t.override_speed = 16'($urandom);
		t.safety_inhibit = ($urandom_range(11) == 0);
		t.drive_enabled = ($urandom_range(9) != 0);

		if ($urandom_range(5) == 0)
			scene_near = !scene_near;
		case ($urandom_range(3))
			0: v = cfg_near + int'($urandom_range(16)) - 8;
			1: begin
				if (scene_near)
					v = (cfg_near > 0) ? int'($urandom_range(cfg_near - 1)) : 0;
				else
					v = cfg_near + int'($urandom_range(16383));
			end
			default: v = int'($urandom_range(16383));
		endcase
		if (v < 0)
			v = 0;
		if (v > 16383)
			v = 16383;
		t.obstacle_mm = OBST_W'(v);

		t.pitch_valid = ($urandom_range(4) != 0);
		if ($urandom_range(2) == 0) begin
			centre = ($urandom_range(1) == 0) ? cfg_pitch_limit : FULL_TURN_TENTHS - cfg_pitch_limit;
			v = centre + int'($urandom_range(8)) - 4;
		end else begin
			v = int'($urandom_range(4095));
		end
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		t.pitch_angle = PITCH_W'(v);
		return t;
	endfunction

	function automatic cfg_t rand_settings();
		cfg_t c;
		c.min_ratio = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
		c.accel_step = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
		c.decel_step = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
		c.base_pressure = 16'($urandom_range(127));
		c.boost_pct = 16'($urandom_range(127));
		c.near_distance = ($urandom_range(1) == 0) ? 16'($urandom_range(1000)) : 16'($urandom);
		c.pitch_limit = 16'($urandom_range(2047));
		return c;
	endfunction

	// ------------------------------------------------------------------
	// drivers, all entered and left on a falling edge
	// ------------------------------------------------------------------

	// offers one tick and waits for its transaction; valid stays high for a
	// back-to-back tick and is only lowered when the sender idles
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {6'd0, t.pitch_angle, t.obstacle_mm, t.override_speed,
			t.curvature, t.lat_error, t.base_speed};
		s_axis_tuser <= {t.pitch_valid, t.drive_enabled, t.safety_inhibit, t.override_active};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_plans.push_back(plan_tick(t));
		@(negedge clk);
	endtask

	// waits until every pending command has come out and the block is idle
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (expected_plans.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MIN_RATIO: cfg_min_ratio = int'(val);
			REG_ACCEL_STEP: cfg_accel = int'(val) & ((1 << STEP_W) - 1);
			REG_DECEL_STEP: cfg_decel = int'(val) & ((1 << STEP_W) - 1);
			REG_BASE_PRESSURE: cfg_base_pressure = int'(val) & ((1 << PCT_W) - 1);
			REG_BOOST_PCT: cfg_boost = int'(val) & ((1 << PCT_W) - 1);
			REG_NEAR_DISTANCE: cfg_near = int'(val) & ((1 << OBST_W) - 1);
			REG_PITCH_LIMIT: cfg_pitch_limit = int'(val) & ((1 << LIMIT_W) - 1);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// writes the whole register set while the block is idle; the spare
	// index gets a write that must change nothing
	task automatic apply_settings(input cfg_t c, input bit poke_spare);
		drain_pipeline();
		cfg_write(REG_MIN_RATIO, c.min_ratio);
		cfg_write(REG_ACCEL_STEP, c.accel_step);
		cfg_write(REG_DECEL_STEP, c.decel_step);
		cfg_write(REG_BASE_PRESSURE, c.base_pressure);
		cfg_write(REG_BOOST_PCT, c.boost_pct);
		cfg_write(REG_NEAR_DISTANCE, c.near_distance);
		cfg_write(REG_PITCH_LIMIT, c.pitch_limit);
		if (poke_spare)
			cfg_write(CFG_IDX_SPARE, 16'hFFFF);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// receiver and checker
	// ------------------------------------------------------------------

	// random ready, or held low for a counted stretch when a stall is requested
	always @(negedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// every output transaction is matched against the oldest pending command
	always @(posedge clk) begin : check_plans
		plan_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_plans.size() == 0) begin
				note_mismatch("output transaction with no tick pending");
			end else begin
				want = expected_plans.pop_front();
				if (m_axis_tdata[SPEED_W-1:0] !== want.planned_speed ||
						m_axis_tuser[USER_WRITE_BIT] !== want.pressure_write ||
						m_axis_tdata[SPEED_W +: PCT_W] !== want.pressure_percent ||
						m_axis_tuser[USER_BOOST_BIT] !== want.boost_active)
					note_mismatch($sformatf({"expected speed %0d write %0b pct %0d boost %0b,",
						" got speed %0d write %0b pct %0d boost %0b"},
						want.planned_speed, want.pressure_write, want.pressure_percent,
						want.boost_active, $signed(m_axis_tdata[SPEED_W-1:0]),
						m_axis_tuser[USER_WRITE_BIT], m_axis_tdata[SPEED_W +: PCT_W],
						m_axis_tuser[USER_BOOST_BIT]));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// speed path at reset settings: extreme speeds, full-scale errors, overrides,
	// zero distance to the target; drive off or inhibit set so no pressure is issued
	task automatic test_speed_ramp();
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(32767, 0, 0, 0, 0, 0, 0, 16383, 0, 0));
		send_tick(mk_tick(32767, -32768, 0, 0, 0, 0, 0, 16383, 0, 0));
		send_tick(mk_tick(0, 0, 0, 1, -32768, 0, 0, 16383, 0, 0));
		send_tick(mk_tick(-32768, 0, -32768, 0, 0, 0, 0, 16383, 0, 0));
		send_tick(mk_tick(0, 0, 0, 1, 32767, 1, 1, 0, 1, 4095));
		send_tick(mk_tick(32767, 32767, -1, 0, -1, 0, 0, 16383, 0, 0));
		send_tick(mk_tick(0, 0, 0, 1, 0, 0, 0, 16383, 0, 0));
		// target equals held speed
		send_tick(mk_tick(0, -1, 1, 0, 0, 0, 0, 16383, 0, 0));
	endtask

	// boost entry and exit by obstacle and by pitch, window edges, inhibit,
	// drive off, the percent cap and an unclamped base level on exit
	task automatic test_suction_boost();
		cfg_t c;
		c.min_ratio = 16'(MIN_RATIO_RST);
		c.accel_step = 16'(ACCEL_RST);
		c.decel_step = 16'(DECEL_RST);
		c.base_pressure = 16'd80;
		c.boost_pct = 16'd15;
		c.near_distance = 16'd200;
		c.pitch_limit = 16'd300;
		apply_settings(c, 1'b0);
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 199, 0, 0));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 200, 0, 0));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 1, 300));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 1, 301));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 1, 3299));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 1, 3300));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 0, 1000));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 1, 4095));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 1, 1, 0, 1, 1000));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 0, 0, 1, 1000));

		// base level above the cap, pitch limit past the half turn
		c.base_pressure = 16'hFFFF;
		c.pitch_limit = 16'hFFFF;
		apply_settings(c, 1'b1);
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 0, 1, 1800));
		send_tick(mk_tick(1000, 0, 0, 0, 0, 0, 1, 16383, 1, 1800));
	endtask

	// all registers at their widest, then all at zero
	task automatic test_config_extremes();
		apply_settings('1, 1'b1);
		// ratio above one means no braking at all
		send_tick(mk_tick(32767, 32767, 32767, 0, 0, 0, 1, 16383, 0, 0));
		send_tick(mk_tick(0, 0, 0, 1, -32768, 0, 1, 16383, 0, 0));
		// full swing is clamped by the widest step
		send_tick(mk_tick(32767, 0, 0, 0, 0, 0, 1, 16383, 0, 0));
		apply_settings('0, 1'b0);
		// zero steps freeze the speed, zero pitch limit boosts any valid pitch strictly between 0 and the full turn
		send_tick(mk_tick(1000, 32767, 0, 0, 0, 0, 1, 16383, 1, 1));
	endtask

	// receiver stalls for a long stretch while ticks keep coming, so the
	// output register fills and the input is held off
	task automatic test_output_backpressure();
		apply_settings(rand_settings(), 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// stall starts at this edge or the next one
		rx_hold_req = 300;
		repeat (24) send_tick(rand_tick());
	endtask

	// three idle patterns, each through four register settings
	task automatic test_random_traffic();
		cfg_t c;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 53;
				end
				1: begin
					send_idle_pct = 53;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 4; s++) begin
				c = rand_settings();
				if (phase == 0 && s == 0)
					c = '0;
				else if (phase == 1 && s == 0)
					c = '1;
				apply_settings(c, 1'b0);
				repeat (140) send_tick(rand_tick());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_speed_ramp();
		test_suction_boost();
		test_config_extremes();
		test_output_backpressure();
		test_random_traffic();
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: filelist.f
hdl/sspb_pkg.sv
hdl/speed_slew_planner_with_boost.sv
hdl/sspb_checker.sv
sim/tb_top.sv
